// ===== rtl/qsd_pkg.sv =====
`default_nettype none

package qsd_pkg;

	localparam int MAX_DIM_DEF = 16384;
	localparam int IDX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(IDX_ENTRIES);

	localparam logic [7:0] OP_RGB  = 8'hFE;
	localparam logic [7:0] OP_RGBA = 8'hFF;
	localparam logic [1:0] TAG_INDEX = 2'b00;
	localparam logic [1:0] TAG_DIFF  = 2'b01;
	localparam logic [1:0] TAG_LUMA  = 2'b10;
	localparam logic [1:0] TAG_RUN   = 2'b11;

	typedef enum logic [1:0] {
		ST_PIXEL   = 2'd0,
		ST_HDR_OK  = 2'd1,
		ST_HDR_BAD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	typedef struct packed {
		logic        valid;
		logic        accept;
		logic        alpha;
		logic [14:0] width;
		logic [14:0] height;
	} hdr_res_t;

	typedef struct packed {
		logic fire;
		logic last;
		logic done;
		logic consume;
	} pix_ctl_t;

	function automatic logic [IDX_W-1:0] px_hash(input pixel_t p);
		logic [IDX_W-1:0] h;
		h = IDX_W'(p.r[IDX_W-1:0] * IDX_W'(3)) + IDX_W'(p.g[IDX_W-1:0] * IDX_W'(5))
			+ IDX_W'(p.b[IDX_W-1:0] * IDX_W'(7)) + IDX_W'(p.a[IDX_W-1:0] * IDX_W'(11));
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/qsd_header.sv =====
`default_nettype none

module qsd_header #(
	parameter int MAX_DIM = qsd_pkg::MAX_DIM_DEF,
	localparam int DIM_W = $clog2(MAX_DIM + 1),
	localparam int PIX_W = $clog2(longint'(MAX_DIM) * longint'(MAX_DIM) + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              start,
	input  logic [7:0]        data_b,
	output qsd_pkg::hdr_res_t res,
	output logic [PIX_W-1:0]  total
);
	import qsd_pkg::*;

	localparam logic [3:0]  HDR_WIDTH = 4'd4;
	localparam logic [3:0]  HDR_HEIGHT = 4'd8;
	localparam logic [3:0]  HDR_CHAN = 4'd12;
	localparam logic [3:0]  HDR_END = 4'd13;
	localparam logic [31:0] MAGIC = 32'h716F6966;
	localparam logic [7:0]  CHAN_RGB = 8'd3;
	localparam logic [7:0]  CHAN_RGBA = 8'd4;

	logic [3:0]  cnt_q;
	logic        magic_ok_q;
	logic        chan_ok_q;
	logic        alpha_q;
	logic [31:0] width_q;
	logic [31:0] height_q;

	logic [3:0]  n;
	logic        mok, cok, a;
	logic [31:0] w, h;
	logic        mok_n, cok_n, a_n;
	logic [31:0] w_n, h_n;
	logic [7:0]  magic_b;
	logic [2*DIM_W-1:0] prod;

	always_comb begin
		n   = start ? 4'd0 : cnt_q;
		mok = start ? 1'b1 : magic_ok_q;
		cok = start ? 1'b1 : chan_ok_q;
		a   = start ? 1'b0 : alpha_q;
		w   = start ? 32'd0 : width_q;
		h   = start ? 32'd0 : height_q;
		magic_b = MAGIC[8 * (3 - n[1:0]) +: 8];
		mok_n = mok;
		cok_n = cok;
		a_n   = a;
		w_n   = w;
		h_n   = h;
		if (n < HDR_WIDTH) begin
			if (data_b != magic_b)
				mok_n = 1'b0;
		end else if (n < HDR_HEIGHT) begin
			w_n = {w[23:0], data_b};
		end else if (n < HDR_CHAN) begin
			h_n = {h[23:0], data_b};
		end else if (n == HDR_CHAN) begin
			a_n   = (data_b == CHAN_RGBA);
			cok_n = (data_b == CHAN_RGB) || (data_b == CHAN_RGBA);
		end
		prod = w[DIM_W-1:0] * h[DIM_W-1:0];
		total = prod[PIX_W-1:0];
		res.valid  = (n == HDR_END);
		res.accept = mok && cok && (w != 32'd0) && (w <= 32'(MAX_DIM))
			&& (h != 32'd0) && (h <= 32'(MAX_DIM));
		res.alpha  = a;
		res.width  = w[14:0];
		res.height = h[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			magic_ok_q <= 1'b1;
			chan_ok_q  <= 1'b1;
			alpha_q    <= 1'b0;
			width_q    <= '0;
			height_q   <= '0;
		end else if (step) begin
			cnt_q      <= n + 4'd1;
			magic_ok_q <= mok_n;
			chan_ok_q  <= cok_n;
			alpha_q    <= a_n;
			width_q    <= w_n;
			height_q   <= h_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/qsd_pixel.sv =====
`default_nettype none

module qsd_pixel #(
	parameter int MAX_DIM = qsd_pkg::MAX_DIM_DEF,
	localparam int PIX_W = $clog2(longint'(MAX_DIM) * longint'(MAX_DIM) + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic                        out_can,
	input  logic                        clear,
	input  logic [PIX_W-1:0]            total,
	input  logic [7:0]                  data_b,
	input  logic                        rd_en,
	input  logic [qsd_pkg::IDX_W-1:0]   rd_addr,
	output qsd_pkg::pixel_t             px,
	output qsd_pkg::pix_ctl_t           ctl
);
	import qsd_pkg::*;

	localparam pixel_t PX_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'hFF};

	pixel_t           idx_mem [IDX_ENTRIES];
	logic [IDX_ENTRIES-1:0] idx_vld_q;
	pixel_t           rdata_q;
	logic             rvld_q;

	logic [7:0]       pend_q;
	logic [2:0]       opcnt_q;
	logic [23:0]      opbuf_q;
	pixel_t           cur_q;
	logic [PIX_W-1:0] left_q;
	logic [5:0]       run_q;

	pixel_t           new_px;
	logic             emit, single, last;
	logic [2:0]       cnt1, need;
	logic [7:0]       pend_n;
	logic [2:0]       opcnt_n;
	logic [23:0]      opbuf_n;
	logic             adv, is_run;
	logic [IDX_W-1:0] wa;
	logic             wr_en;

	always_comb begin
		new_px  = cur_q;
		emit    = 1'b0;
		single  = 1'b0;
		is_run  = 1'b0;
		pend_n  = pend_q;
		opcnt_n = opcnt_q;
		opbuf_n = opbuf_q;
		cnt1    = opcnt_q + 3'd1;
		need    = (pend_q == OP_RGB) ? 3'd3 : (pend_q == OP_RGBA) ? 3'd4 : 3'd1;
		if (pend_q != 8'd0) begin
			if (cnt1 < need) begin
				opcnt_n = cnt1;
				opbuf_n = {opbuf_q[15:0], data_b};
			end else begin
				pend_n  = 8'd0;
				opcnt_n = 3'd0;
				opbuf_n = 24'd0;
				emit    = 1'b1;
				single  = 1'b1;
				if (pend_q == OP_RGB) begin
					new_px.r = opbuf_q[15:8];
					new_px.g = opbuf_q[7:0];
					new_px.b = data_b;
				end else if (pend_q == OP_RGBA) begin
					new_px.r = opbuf_q[23:16];
					new_px.g = opbuf_q[15:8];
					new_px.b = opbuf_q[7:0];
					new_px.a = data_b;
				end else begin
					// luma: green diff biased by 32, red/blue relative to it biased by 8
					new_px.r = cur_q.r + {2'b0, pend_q[5:0]} + 8'd216 + {4'b0, data_b[7:4]};
					new_px.g = cur_q.g + {2'b0, pend_q[5:0]} + 8'd224;
					new_px.b = cur_q.b + {2'b0, pend_q[5:0]} + 8'd216 + {4'b0, data_b[3:0]};
				end
			end
		end else if (data_b == OP_RGB || data_b == OP_RGBA || data_b[7:6] == TAG_LUMA) begin
			pend_n  = data_b;
			opcnt_n = 3'd0;
			opbuf_n = 24'd0;
		end else begin
			emit = 1'b1;
			case (data_b[7:6])
				TAG_INDEX: begin
					single = 1'b1;
					new_px = rvld_q ? rdata_q : '0;
				end
				TAG_DIFF: begin
					single   = 1'b1;
					new_px.r = cur_q.r + {6'b0, data_b[5:4]} + 8'd254;
					new_px.g = cur_q.g + {6'b0, data_b[3:2]} + 8'd254;
					new_px.b = cur_q.b + {6'b0, data_b[1:0]} + 8'd254;
				end
				default: begin
					is_run = 1'b1;
				end
			endcase
		end
		ctl.done = (left_q == PIX_W'(1));
		last     = single || (run_q == data_b[5:0]) || ctl.done;
		adv      = go && (!emit || out_can);
		ctl.fire = adv && emit;
		ctl.last = last;
		ctl.consume = adv && (!emit || last);
		wr_en    = adv && single;
		wa       = px_hash(new_px);
		px       = new_px;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			idx_mem[wa] <= new_px;
		if (rd_en)
			rdata_q <= (wr_en && wa == rd_addr) ? new_px : idx_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (clear)
				rvld_q <= 1'b0;
			else if (rd_en)
				rvld_q <= idx_vld_q[rd_addr] || (wr_en && wa == rd_addr);
			if (clear)
				idx_vld_q <= '0;
			else if (wr_en)
				idx_vld_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			opcnt_q <= '0;
			opbuf_q <= '0;
			cur_q   <= PX_RESET;
			left_q  <= '0;
			run_q   <= '0;
		end else if (clear) begin
			pend_q  <= '0;
			opcnt_q <= '0;
			opbuf_q <= '0;
			cur_q   <= PX_RESET;
			left_q  <= total;
			run_q   <= '0;
		end else if (adv) begin
			pend_q  <= pend_n;
			opcnt_q <= opcnt_n;
			opbuf_q <= opbuf_n;
			cur_q   <= new_px;
			if (emit)
				left_q <= left_q - PIX_W'(1);
			if (is_run)
				run_q <= last ? 6'd0 : run_q + 6'd1;
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (idx_vld_q == '0) && (pend_q == 8'd0) && !rvld_q)
		else $error("index or pending op not cleared at frame start");

	a_pixels_remain: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> left_q != '0)
		else $error("decoding with no pixels left in frame");

	a_run_alone: assert property (@(posedge clk) disable iff (!arst_n)
		run_q != 6'd0 |-> pend_q == 8'd0 && run_q < 6'd62)
		else $error("run counter out of step");

endmodule

`default_nettype wire

// ===== rtl/qoi_stream_decoder.sv =====
// QOI image decoder, one file byte per input beat.
// Input: s_axis beats carry one byte in tdata[7:0]; tuser high marks the first
// header byte of a new file and restarts the decoder. After reset the first
// bytes are read as a header even without that mark.
// Output: m_axis beats carry one result each. tuser[1:0] is the status (pixel,
// header accepted, header rejected), tuser[2] flags the pixel that completes
// width*height, tlast flags the final pixel produced by an input byte.
// The header result comes on the 14th byte and carries the dimensions; pixel
// beats repeat them. Bytes after a rejected header or a finished frame are
// dropped until the next start mark.
// An accepted byte is registered in the decode stage, and its result in the output register.
// Throughput: one byte per cycle while the output is not stalled; a run byte holds
// the input until all its pixels (1 to 62) have gone through the single pixel output register.
// The 64-entry color index uses per-entry valid bits cleared together at reset
// and at each accepted header, so there is no clearing pass.
// When the receiver stalls the output beat holds, the byte in the decode stage
// waits and tready drops; bytes that produce no result still pass.
`default_nettype none

module qoi_stream_decoder #(
	parameter int MAX_DIM = qsd_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // red, green, blue, alpha_value, has_alpha,
	                                   // image_width, image_height, pad
	output logic        m_axis_tlast,  // last_of_run
	output logic [2:0]  m_axis_tuser   // [1:0] status, [2] frame_done
);
	import qsd_pkg::*;

	localparam int PIX_W = $clog2(longint'(MAX_DIM) * longint'(MAX_DIM) + 1);

	logic       vld_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	phase_t     phase_q, phase_n, phase_eff;
	hdr_res_t   hres;
	pix_ctl_t   pctl;
	pixel_t     px;
	logic [PIX_W-1:0] total;

	logic       in_fire, out_can, consume;
	logic       hdr_go, hdr_adv, pix_go, clear, load_hdr, load;

	status_t     status_q;
	logic [7:0]  r_q, g_q, b_q, a_q;
	logic        has_a_q, last_q, done_q, out_vld_q;
	logic [14:0] w_q, h_q;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_can = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !vld_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_axis_tready)
			vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	qsd_header #(.MAX_DIM(MAX_DIM)) u_header (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (hdr_adv),
		.start  (start_s1),
		.data_b (data_s1),
		.res    (hres),
		.total  (total)
	);

	qsd_pixel #(.MAX_DIM(MAX_DIM)) u_pixel (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (pix_go),
		.out_can (out_can),
		.clear   (clear),
		.total   (total),
		.data_b  (data_s1),
		.rd_en   (in_fire),
		.rd_addr (s_axis_tdata[IDX_W-1:0]),
		.px      (px),
		.ctl     (pctl)
	);

	// outputs of the phase machine
	always_comb begin
		phase_eff = start_s1 ? PH_HEADER : phase_q;
		hdr_go  = vld_s1 && (phase_eff == PH_HEADER);
		pix_go  = vld_s1 && (phase_eff == PH_PIXELS);
		hdr_adv = hdr_go && (!hres.valid || out_can);
		consume = (vld_s1 && phase_eff == PH_IDLE) || hdr_adv || pctl.consume;
		load_hdr = hdr_adv && hres.valid;
		clear   = load_hdr && hres.accept;
		load    = load_hdr || pctl.fire;
	end

	// next phase
	always_comb begin
		phase_n = phase_q;
		if (hdr_adv) begin
			if (!hres.valid)
				phase_n = PH_HEADER;
			else if (hres.accept)
				phase_n = PH_PIXELS;
			else
				phase_n = PH_IDLE;
		end else if (pctl.fire && pctl.done) begin
			phase_n = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_HEADER;
		else
			phase_q <= phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (load)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (load_hdr) begin
				status_q <= hres.accept ? ST_HDR_OK : ST_HDR_BAD;
				r_q      <= 8'd0;
				g_q      <= 8'd0;
				b_q      <= 8'd0;
				a_q      <= 8'd0;
				has_a_q  <= hres.accept && hres.alpha;
				last_q   <= 1'b0;
				done_q   <= 1'b0;
				w_q      <= hres.accept ? hres.width : 15'd0;
				h_q      <= hres.accept ? hres.height : 15'd0;
			end else begin
				status_q <= ST_PIXEL;
				r_q      <= px.r;
				g_q      <= px.g;
				b_q      <= px.b;
				a_q      <= hres.alpha ? px.a : 8'hFF;
				has_a_q  <= hres.alpha;
				last_q   <= pctl.last;
				done_q   <= pctl.done;
				w_q      <= hres.width;
				h_q      <= hres.height;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, h_q, w_q, has_a_q, a_q, b_q, g_q, r_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = {done_q, status_q};

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
		else $error("frame end beat without end of run");

	a_hdr_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] != ST_PIXEL)
		|-> !m_axis_tlast && !m_axis_tuser[2] && (m_axis_tdata[31:0] == 32'd0))
		else $error("header beat carries pixel fields");

	a_idle_drops: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !start_s1 && (phase_q == PH_IDLE) |-> s_axis_tready)
		else $error("dropped byte stalled the input");

	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		pctl.fire && pctl.done |=> phase_q == PH_IDLE)
		else $error("phase not idle after final pixel");

endmodule

`default_nettype wire

// ===== test/qoi_stream_decoder_checker.sv =====
`timescale 1ns / 1ps

module qoi_stream_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tlast,
	input  logic [2:0]  m_tuser,
	output int          fail_count,
	output int          backlog
);

	import qsd_pkg::*;

	localparam logic [31:0] QOI_MAGIC = 32'h716F6966;

	typedef struct packed {
		logic [1:0]  status;
		pixel_t      px;
		logic        has_alpha;
		logic        last;
		logic        done;
		logic [14:0] width;
		logic [14:0] height;
	} beat_t;

	beat_t       awaited[$];
	phase_t      stage;
	logic [3:0]  hdr_count;
	logic [31:0] w_acc;
	logic [31:0] h_acc;
	logic        alpha_on;
	logic        magic_ok;
	logic        chan_ok;
	logic [28:0] to_go;
	pixel_t      palette[IDX_ENTRIES];
	pixel_t      cur;
	logic [7:0]  held_op;
	logic [2:0]  arg_count;
	logic [23:0] arg_buf;

	function automatic void queue_beat(input logic [1:0] status, input pixel_t px,
			input logic ha, input logic last, input logic done,
			input logic [14:0] w, input logic [14:0] h);
		beat_t bt;
		bt.status    = status;
		bt.px        = px;
		bt.has_alpha = ha;
		bt.last      = last;
		bt.done      = done;
		bt.width     = w;
		bt.height    = h;
		awaited.push_back(bt);
	endfunction

	function automatic void clear_frame();
		foreach (palette[i])
			palette[i] = '0;
		cur       = {24'd0, 8'hFF};
		held_op   = 8'd0;
		arg_count = 3'd0;
		arg_buf   = 24'd0;
	endfunction

	function automatic void restart_header();
		stage     = PH_HEADER;
		hdr_count = 4'd0;
		w_acc     = 32'd0;
		h_acc     = 32'd0;
		alpha_on  = 1'b0;
		to_go     = 29'd0;
		magic_ok  = 1'b1;
		chan_ok   = 1'b1;
		clear_frame();
	endfunction

	function automatic void emit_run(input int count);
		int k;
		if (count > to_go)
			count = to_go;
		for (k = 0; k < count; k++) begin
			to_go = to_go - 1'b1;
			queue_beat(ST_PIXEL, {cur.r, cur.g, cur.b, (alpha_on ? cur.a : 8'hFF)}, alpha_on,
				k == count - 1, to_go == 0, w_acc[14:0], h_acc[14:0]);
		end
		if (to_go == 0)
			stage = PH_IDLE;
	endfunction

	function automatic void emit_single();
		int slot;
		slot = (int'(cur.r) * 3 + int'(cur.g) * 5 + int'(cur.b) * 7 + int'(cur.a) * 11)
			% IDX_ENTRIES;
		palette[slot] = cur;
		emit_run(1);
	endfunction

	function automatic void decode_byte(input logic [7:0] data, input logic start);
		logic [3:0] n;
		int         need;
		logic [5:0] dg;
		if (start)
			restart_header();
		case (stage)
			PH_HEADER: begin
				n = hdr_count;
				hdr_count = hdr_count + 1'b1;
				if (n < 4) begin
					if (data != 8'(QOI_MAGIC >> (24 - 8 * n)))
						magic_ok = 1'b0;
				end else if (n < 8) begin
					w_acc = {w_acc[23:0], data};
				end else if (n < 12) begin
					h_acc = {h_acc[23:0], data};
				end else if (n == 12) begin
					alpha_on = (data == 8'd4);
					chan_ok  = (data == 8'd3 || data == 8'd4);
				end else if (magic_ok && chan_ok && w_acc >= 1 && w_acc <= MAX_DIM_DEF
						&& h_acc >= 1 && h_acc <= MAX_DIM_DEF) begin
					to_go = 29'(w_acc * h_acc);
					stage = PH_PIXELS;
					clear_frame();
					queue_beat(ST_HDR_OK, '0, alpha_on, 1'b0, 1'b0, w_acc[14:0], h_acc[14:0]);
				end else begin
					stage = PH_IDLE;
					queue_beat(ST_HDR_BAD, '0, 1'b0, 1'b0, 1'b0, 15'd0, 15'd0);
				end
			end
			PH_PIXELS: begin
				if (held_op != 8'd0) begin
					need = (held_op == OP_RGB) ? 3 : (held_op == OP_RGBA) ? 4 : 1;
					arg_count = arg_count + 1'b1;
					if (arg_count < need) begin
						arg_buf = {arg_buf[15:0], data};
					end else begin
						if (held_op == OP_RGB) begin
							cur.r = arg_buf[15:8];
							cur.g = arg_buf[7:0];
							cur.b = data;
						end else if (held_op == OP_RGBA) begin
							cur.r = arg_buf[23:16];
							cur.g = arg_buf[15:8];
							cur.b = arg_buf[7:0];
							cur.a = data;
						end else begin
							// luma: green delta biased by 32, red/blue relative to it
							dg = held_op[5:0];
							cur.r = cur.r + dg - 8'd40 + data[7:4];
							cur.g = cur.g + dg - 8'd32;
							cur.b = cur.b + dg - 8'd40 + data[3:0];
						end
						held_op   = 8'd0;
						arg_count = 3'd0;
						arg_buf   = 24'd0;
						emit_single();
					end
				end else if (data == OP_RGB || data == OP_RGBA || data[7:6] == TAG_LUMA) begin
					held_op   = data;
					arg_count = 3'd0;
					arg_buf   = 24'd0;
				end else if (data[7:6] == TAG_INDEX) begin
					cur = palette[data[5:0]];
					emit_single();
				end else if (data[7:6] == TAG_DIFF) begin
					cur.r = cur.r + data[5:4] - 8'd2;
					cur.g = cur.g + data[3:2] - 8'd2;
					cur.b = cur.b + data[1:0] - 8'd2;
					emit_single();
				end else begin
					emit_run(int'(data[5:0]) + 1);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_beat(input beat_t want);
		check_field("status", want.status, m_tuser[1:0]);
		check_field("red", want.px.r, m_tdata[7:0]);
		check_field("green", want.px.g, m_tdata[15:8]);
		check_field("blue", want.px.b, m_tdata[23:16]);
		check_field("alpha_value", want.px.a, m_tdata[31:24]);
		check_field("has_alpha", want.has_alpha, m_tdata[32]);
		check_field("image_width", want.width, m_tdata[47:33]);
		check_field("image_height", want.height, m_tdata[62:48]);
		check_field("last_of_run", want.last, m_tlast);
		check_field("frame_done", want.done, m_tuser[2]);
	endfunction

	initial begin
		fail_count = 0;
		backlog    = 0;
		restart_header();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got tdata %h tuser %h tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					check_beat(awaited.pop_front());
				end
			end
			backlog = awaited.size();
		end
	end

endmodule

// ===== test/qoi_stream_decoder_tb.sv =====
`timescale 1ns / 1ps

module qoi_stream_decoder_tb;

	import qsd_pkg::*;

	localparam int          LIMIT       = 1000000;
	localparam int          HOLD_CYCLES = 400;
	localparam int          PHASE_BYTES = 60;
	localparam logic [31:0] QOI_MAGIC   = 32'h716F6966;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;
	int          fail_count;
	int          backlog;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_taken   = 1'b0;
	int hold_left    = 0;
	int sent_bytes   = 0;
	int cycle_count  = 0;

	always #1 clk = ~clk;

	qoi_stream_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser)
	);

	qoi_stream_decoder_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	always @(negedge clk) begin
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("qoi_stream_decoder verification failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] data, input logic start);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_bytes++;
	endtask

	task automatic send_header(input logic [31:0] magic, input logic [31:0] w,
			input logic [31:0] h, input logic [7:0] ch, input logic start);
		int k;
		for (k = 0; k < 4; k++)
			send_byte(magic[31 - 8 * k -: 8], start && k == 0);
		for (k = 0; k < 4; k++)
			send_byte(w[31 - 8 * k -: 8], 1'b0);
		for (k = 0; k < 4; k++)
			send_byte(h[31 - 8 * k -: 8], 1'b0);
		send_byte(ch, 1'b0);
		send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_op(output int px);
		logic [7:0] op;
		px = 1;
		case ($urandom_range(5))
			0: begin
				send_byte(OP_RGB, 1'b0);
				repeat (3) send_byte(8'($urandom), 1'b0);
			end
			1: begin
				send_byte(OP_RGBA, 1'b0);
				repeat (4) send_byte(8'($urandom), 1'b0);
			end
			2: send_byte({TAG_INDEX, 6'($urandom)}, 1'b0);
			3: send_byte({TAG_DIFF, 6'($urandom)}, 1'b0);
			4: begin
				send_byte({TAG_LUMA, 6'($urandom)}, 1'b0);
				send_byte(8'($urandom), 1'b0);
			end
			default: begin
				// short runs mostly; 61 is the longest legal run code
				op = {TAG_RUN, 6'($urandom_range(($urandom_range(3) == 0) ? 61 : 7))};
				send_byte(op, 1'b0);
				px = int'(op[5:0]) + 1;
			end
		endcase
	endtask

	task automatic send_frame(input int w, input int h, input logic [7:0] ch,
			input int max_ops);
		int made;
		int ops;
		int px;
		send_header(QOI_MAGIC, w, h, ch, 1'b1);
		made = 0;
		ops  = 0;
		while (made < w * h && ops < max_ops) begin
			send_op(px);
			made += px;
			ops++;
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (backlog != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int tx, input int rx);
		int          target;
		int          sel;
		logic [31:0] magic;
		logic [31:0] bw;
		logic [31:0] bh;
		logic [7:0]  ch;
		tx_idle_pct  = tx;
		rx_stall_pct = rx;
		target = sent_bytes + PHASE_BYTES;
		while (sent_bytes < target) begin
			sel = $urandom_range(99);
			if (sel < 75) begin
				send_frame($urandom_range(1, 8), $urandom_range(1, 6), 8'($urandom_range(3, 4)),
					($urandom_range(9) == 0) ? $urandom_range(1, 6) : 1000);
				repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
			end else if (sel < 80) begin
				// big dimensions, cut short by the next start mark
				send_frame(($urandom_range(1) != 0) ? MAX_DIM_DEF : $urandom_range(1, MAX_DIM_DEF),
					$urandom_range(1, MAX_DIM_DEF), 8'($urandom_range(3, 4)),
					$urandom_range(4, 12));
			end else if (sel < 92) begin
				magic = QOI_MAGIC;
				bw    = $urandom_range(1, 8);
				bh    = $urandom_range(1, 8);
				ch    = 8'($urandom_range(3, 4));
				case ($urandom_range(5))
					0: magic = QOI_MAGIC ^ (32'd1 << $urandom_range(31));
					1: begin
						if ($urandom_range(1) != 0)
							bw = 32'd0;
						else
							bh = 32'd0;
					end
					2: bw = $urandom_range(32'hFFFFFFFF, MAX_DIM_DEF + 1);
					3: bh = $urandom_range(32'hFFFFFFFF, MAX_DIM_DEF + 1);
					4: begin
						do
							ch = 8'($urandom);
						while (ch == 8'd3 || ch == 8'd4);
					end
					default: bw = MAX_DIM_DEF + 1;
				endcase
				send_header(magic, bw, bh, ch, 1'b1);
				repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
			end else if (sel < 96) begin
				send_byte(8'($urandom), 1'b1);
				repeat ($urandom_range(12)) send_byte(8'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(7) == 0);
			end
		end
		wait_drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first header after reset comes without a start mark
		send_header(QOI_MAGIC, 2, 3, 8'd4, 1'b0);
		send_byte(OP_RGBA, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(OP_RGB, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte({TAG_DIFF, 6'h00}, 1'b0);
		send_byte({TAG_DIFF, 6'h3F}, 1'b0);
		send_byte({TAG_LUMA, 6'h00}, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte({TAG_LUMA, 6'h3F}, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte({TAG_INDEX, 6'h00}, 1'b0);

		// alpha update in a 3-channel file feeds the hash
		send_header(QOI_MAGIC, 1, MAX_DIM_DEF, 8'd3, 1'b1);
		send_byte(OP_RGBA, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h04, 1'b0);
		send_byte({TAG_INDEX, 6'h00}, 1'b0);
		send_byte({TAG_INDEX, 6'd14}, 1'b0);
		send_byte({TAG_RUN, 6'd61}, 1'b0);
		send_byte({TAG_DIFF, 6'h15}, 1'b0);

		send_header(QOI_MAGIC, MAX_DIM_DEF, MAX_DIM_DEF, 8'd4, 1'b1);
		send_byte({TAG_RUN, 6'd61}, 1'b0);

		// run clipped at frame end
		send_header(QOI_MAGIC, 3, 1, 8'd3, 1'b1);
		send_byte({TAG_RUN, 6'd61}, 1'b0);
		send_byte(OP_RGB, 1'b0);

		send_header(QOI_MAGIC ^ 32'd1, 4, 4, 8'd3, 1'b1);
		send_header(QOI_MAGIC, 0, 4, 8'd3, 1'b1);
		send_header(QOI_MAGIC, 4, MAX_DIM_DEF + 1, 8'd4, 1'b1);
		send_header(QOI_MAGIC, 4, 4, 8'd5, 1'b1);
		wait_drain();

		@(posedge clk);
		hold_request = 1'b1;
		send_frame(8, 8, 8'd4, 1000);
		send_frame(4, 4, 8'd3, 1000);
		wait_drain();

		random_phase(0, 0);
		random_phase(87, 0);
		random_phase(0, 87);
		random_phase(30, 30);

		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("qoi_stream_decoder verification clean");
		else
			$display("qoi_stream_decoder verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/qsd_pkg.sv
rtl/qsd_header.sv
rtl/qsd_pixel.sv
rtl/qoi_stream_decoder.sv
test/qoi_stream_decoder_checker.sv
test/qoi_stream_decoder_tb.sv
